// ----- rtl/vp8pd_pkg.sv -----
// Package for the VP8 RTP payload descriptor parser.
// Holds the parse phase type, the result record, field masks and phase helpers.
// No dependencies.
package vp8pd_pkg;

    // Parse phases in payload order
    typedef enum logic [3:0] {
        PH_FIRST = 4'd0,
        PH_EXT   = 4'd1,
        PH_PID0  = 4'd2,
        PH_PID1  = 4'd3,
        PH_TL0   = 4'd4,
        PH_TIDK  = 4'd5,
        PH_TAG0  = 4'd6,
        PH_TAG1  = 4'd7,
        PH_TAG2  = 4'd8,
        PH_DONE  = 4'd9
    } t_phase;

    // Field masks of the descriptor bytes
    localparam logic [7:0] X_MASK    = 8'h80;  // first byte: extension present
    localparam logic [7:0] S_MASK    = 8'h10;  // first byte: start of partition
    localparam logic [7:0] PID_MASK  = 8'h0F;  // first byte: partition index
    localparam logic [7:0] I_MASK    = 8'h80;  // extension: picture id present
    localparam logic [7:0] L_MASK    = 8'h40;  // extension: TL0PICIDX present
    localparam logic [7:0] TK_MASK   = 8'h30;  // extension: T or K, TID/KEYIDX byte present
    localparam logic [7:0] M_MASK    = 8'h80;  // picture id: long form
    localparam logic [7:0] PIC7_MASK = 8'h7F;  // picture id: low seven bits

    localparam logic [3:0] TAG_BYTES = 4'd3;

    // One parse result
    typedef struct packed {
        logic        status;
        logic [2:0]  descriptor_length;
        logic [3:0]  consumed_length;
        logic [7:0]  first_byte;
        logic [7:0]  extension_byte;
        logic [14:0] picture_id;
        logic        picture_id_long;
        logic [7:0]  tl0_pic_index;
        logic [7:0]  tid_key_byte;
        logic [4:0]  frame_tag_bits;
        logic [18:0] part0_size;
        logic        key_frame;
    } t_result;

    // Frame tag follows when S=1 and partition index is zero
    function automatic logic has_tag(input logic [7:0] fb);
        return ((fb & S_MASK) != 8'h00) && ((fb & PID_MASK) == 8'h00);
    endfunction

    // Whether a phase is part of this packet's header
    function automatic logic phase_needed(input t_phase q, input logic [7:0] fb,
                                          input logic [7:0] ext, input logic pid_long);
        logic x;
        logic need;
        x = (fb & X_MASK) != 8'h00;
        unique case (q)
            PH_EXT:  need = x;
            PH_PID0: need = x && ((ext & I_MASK) != 8'h00);
            PH_PID1: need = x && ((ext & I_MASK) != 8'h00) && pid_long;
            PH_TL0:  need = x && ((ext & L_MASK) != 8'h00);
            PH_TIDK: need = x && ((ext & TK_MASK) != 8'h00);
            PH_TAG0, PH_TAG1, PH_TAG2: need = has_tag(fb);
            default: need = 1'b0;
        endcase
        return need;
    endfunction

    // First needed phase after p, or done
    function automatic t_phase next_phase(input t_phase p, input logic [7:0] fb,
                                          input logic [7:0] ext, input logic pid_long);
        t_phase res;
        logic   found;
        res   = PH_DONE;
        found = 1'b0;
        for (int i = 1; i < 9; i++) begin
            if (!found && (4'(i) > p) && phase_needed(t_phase'(4'(i)), fb, ext, pid_long)) begin
                res   = t_phase'(4'(i));
                found = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

// ----- rtl/vp8pd_parse.sv -----
// Per-packet parse state and the combinational step of the descriptor parser.
// Depends on vp8pd_pkg.
module vp8pd_parse
    import vp8pd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_res_valid,
    output t_result    o_result
);

    t_phase      r_phase, n_phase;
    logic        r_done;
    logic [3:0]  r_count, n_count;
    logic [7:0]  r_first, n_first;
    logic [7:0]  r_ext, n_ext;
    logic [14:0] r_pid, n_pid;
    logic        r_pid_long, n_pid_long;
    logic [7:0]  r_tl0, n_tl0;
    logic [7:0]  r_tidk, n_tidk;
    logic [23:0] r_tag, n_tag;

    logic        fin;
    logic        tag_full;
    logic [3:0]  tag_drop;

    // Store the byte into the field of the current phase
    always_comb begin
        n_first    = r_first;
        n_ext      = r_ext;
        n_pid      = r_pid;
        n_pid_long = r_pid_long;
        n_tl0      = r_tl0;
        n_tidk     = r_tidk;
        n_tag      = r_tag;
        unique case (r_phase)
            PH_FIRST: n_first = i_data_byte;
            PH_EXT:   n_ext = i_data_byte;
            PH_PID0: begin
                n_pid_long = (i_data_byte & M_MASK) != 8'h00;
                n_pid      = {8'h00, i_data_byte[6:0] & PIC7_MASK[6:0]};
            end
            PH_PID1:  n_pid = {r_pid[6:0], i_data_byte};
            PH_TL0:   n_tl0 = i_data_byte;
            PH_TIDK:  n_tidk = i_data_byte;
            PH_TAG0:  n_tag = {16'h0000, i_data_byte};
            PH_TAG1:  n_tag = {r_tag[23:16], i_data_byte, r_tag[7:0]};
            PH_TAG2:  n_tag = {i_data_byte, r_tag[15:0]};
            default: ;
        endcase
        n_count = r_count + 4'd1;
        n_phase = next_phase(r_phase, n_first, n_ext, n_pid_long);
    end

    // Build the result from the updated fields
    always_comb begin
        fin      = (n_phase == PH_DONE);
        tag_full = fin && has_tag(n_first);
        if (tag_full) begin
            tag_drop = TAG_BYTES;
        end else if (!fin && (n_phase >= PH_TAG0) && (n_phase <= PH_TAG2)) begin
            tag_drop = 4'(n_phase) - 4'(PH_TAG0);
        end else begin
            tag_drop = 4'd0;
        end
        o_res_valid                = i_accept && !r_done && (fin || i_last_byte);
        o_result.status            = !fin;
        o_result.descriptor_length = 3'(n_count - tag_drop);
        o_result.consumed_length   = n_count;
        o_result.first_byte        = n_first;
        o_result.extension_byte    = n_ext;
        o_result.picture_id        = n_pid;
        o_result.picture_id_long   = n_pid_long;
        o_result.tl0_pic_index     = n_tl0;
        o_result.tid_key_byte      = n_tidk;
        o_result.frame_tag_bits    = tag_full ? n_tag[4:0] : 5'd0;
        o_result.part0_size        = tag_full ? n_tag[23:5] : 19'd0;
        o_result.key_frame         = tag_full && !n_tag[0];
    end

    // Advance on each transfer until the header is done; clear at reset or at the last byte of a packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_phase    <= PH_FIRST;
            r_done     <= 1'b0;
            r_count    <= 4'd0;
            r_first    <= 8'h00;
            r_ext      <= 8'h00;
            r_pid      <= 15'd0;
            r_pid_long <= 1'b0;
            r_tl0      <= 8'h00;
            r_tidk     <= 8'h00;
            r_tag      <= 24'd0;
        end else if (i_accept && !r_done) begin
            r_phase    <= n_phase;
            r_done     <= fin;
            r_count    <= n_count;
            r_first    <= n_first;
            r_ext      <= n_ext;
            r_pid      <= n_pid;
            r_pid_long <= n_pid_long;
            r_tl0      <= n_tl0;
            r_tidk     <= n_tidk;
            r_tag      <= n_tag;
        end
    end

endmodule

// ----- rtl/vp8_payload_descriptor_parser.sv -----
// Top level of the VP8 RTP payload descriptor parser: parse step plus result register.
// Depends on vp8pd_pkg and vp8pd_parse.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one payload byte per transfer,
//   with i_last_byte high on the final byte of the RTP payload.
//   Output channel (o_out_valid / i_out_ready) carries one result per packet:
//   status 0 on the byte that completes the descriptor (and frame tag when S=1
//   and partition index 0), or status 1 on the last byte if the header is cut short.
//   Bytes after a completed header are dropped until the last byte of the packet.
//   Latency: a result is presented in the cycle after the transfer of the byte
//   that produces it. Throughput: one byte per cycle; the parse step is a single
//   combinational pass from the phase register into the result register.
//   Stall: while a result waits and i_out_ready is low, o_in_ready is low and
//   bytes are held off; a result taken in the same cycle frees the register for
//   a new one, so bytes keep flowing at full rate with an always-ready receiver.
//   Reset (synchronous, active low) clears the phase, counters, field stores and
//   the result valid flag; the block then expects the first byte of a packet.
module vp8_payload_descriptor_parser
    import vp8pd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic [2:0]  o_descriptor_length,
    output logic [3:0]  o_consumed_length,
    output logic [7:0]  o_first_byte,
    output logic [7:0]  o_extension_byte,
    output logic [14:0] o_picture_id,
    output logic        o_picture_id_long,
    output logic [7:0]  o_tl0_pic_index,
    output logic [7:0]  o_tid_key_byte,
    output logic [4:0]  o_frame_tag_bits,
    output logic [18:0] o_part0_size,
    output logic        o_key_frame
);

    logic    accept;
    logic    res_valid;
    t_result result;
    logic    r_out_valid;
    t_result r_result;

    // Take a byte whenever the result register is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    vp8pd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_result <= result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_result.status;
    assign o_descriptor_length = r_result.descriptor_length;
    assign o_consumed_length   = r_result.consumed_length;
    assign o_first_byte        = r_result.first_byte;
    assign o_extension_byte    = r_result.extension_byte;
    assign o_picture_id        = r_result.picture_id;
    assign o_picture_id_long   = r_result.picture_id_long;
    assign o_tl0_pic_index     = r_result.tl0_pic_index;
    assign o_tid_key_byte      = r_result.tid_key_byte;
    assign o_frame_tag_bits    = r_result.frame_tag_bits;
    assign o_part0_size        = r_result.part0_size;
    assign o_key_frame         = r_result.key_frame;

endmodule

// ----- rtl/vp8pd_checker.sv -----
// Port-level checks for the VP8 RTP payload descriptor parser, bound to its top level.
// Depends on vp8pd_pkg for shared constants.
module vp8pd_checker
    import vp8pd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_status,
    input logic [2:0]  o_descriptor_length,
    input logic [3:0]  o_consumed_length,
    input logic [7:0]  o_first_byte,
    input logic        o_key_frame
);

    // Free result register must not stall the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // A new result only follows an input transfer
    a_result_from_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready))
        else $error("result appeared without an input transfer");

    // Stalled result holds its payload
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status)
            && $stable(o_consumed_length) && $stable(o_first_byte)))
        else $error("stalled result changed");

    // Consumed byte count stays within the header bound
    a_consumed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_consumed_length != 4'd0) && (o_consumed_length <= 4'd9))
        else $error("consumed length out of range");

    // A key frame has a complete frame tag after the descriptor
    a_key_frame_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_key_frame) |-> (!o_status
            && (o_consumed_length == ({1'b0, o_descriptor_length} + TAG_BYTES))))
        else $error("key frame without full frame tag");

endmodule

bind vp8_payload_descriptor_parser vp8pd_checker u_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_ready          (o_in_ready),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_status            (o_status),
    .o_descriptor_length (o_descriptor_length),
    .o_consumed_length   (o_consumed_length),
    .o_first_byte        (o_first_byte),
    .o_key_frame         (o_key_frame)
);

// ----- dv/tb_vp8_payload_descriptor_parser.sv -----
// Testbench for vp8_payload_descriptor_parser: directed rows, then random packets,
// checked against an in-bench parser model with per-field comparison, save rows that carry their own expected result.
// Depends on vp8pd_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_vp8_payload_descriptor_parser;
    import vp8pd_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_status;
    logic [2:0]  o_descriptor_length;
    logic [3:0]  o_consumed_length;
    logic [7:0]  o_first_byte;
    logic [7:0]  o_extension_byte;
    logic [14:0] o_picture_id;
    logic        o_picture_id_long;
    logic [7:0]  o_tl0_pic_index;
    logic [7:0]  o_tid_key_byte;
    logic [4:0]  o_frame_tag_bits;
    logic [18:0] o_part0_size;
    logic        o_key_frame;

    vp8_payload_descriptor_parser i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_data_byte         (i_data_byte),
        .i_last_byte         (i_last_byte),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_descriptor_length (o_descriptor_length),
        .o_consumed_length   (o_consumed_length),
        .o_first_byte        (o_first_byte),
        .o_extension_byte    (o_extension_byte),
        .o_picture_id        (o_picture_id),
        .o_picture_id_long   (o_picture_id_long),
        .o_tl0_pic_index     (o_tl0_pic_index),
        .o_tid_key_byte      (o_tid_key_byte),
        .o_frame_tag_bits    (o_frame_tag_bits),
        .o_part0_size        (o_part0_size),
        .o_key_frame         (o_key_frame)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       typed;
        t_result    want;
    } t_stim_row;

    // Parser model state
    t_phase      p_phase;
    logic        p_done;
    logic [3:0]  p_count;
    logic [7:0]  p_fb;
    logic [7:0]  p_ext;
    logic [14:0] p_pid;
    logic        p_long;
    logic [7:0]  p_tl0;
    logic [7:0]  p_tidk;
    logic [23:0] p_tag;

    t_result     pending_results[$];
    int unsigned mismatch_count = 0;
    logic        row_typed = 1'b0;
    t_result     row_want = '0;
    int unsigned burst_left = 0;
    logic        sender_idles = 1'b1;
    int unsigned sent_items = 0;

    // Reset the model to the start of a packet
    function automatic void clear_parse();
        p_phase = PH_FIRST;
        p_done  = 1'b0;
        p_count = '0;
        p_fb    = '0;
        p_ext   = '0;
        p_pid   = '0;
        p_long  = 1'b0;
        p_tl0   = '0;
        p_tidk  = '0;
        p_tag   = '0;
    endfunction

    function automatic logic carries_frame_tag();
        return ((p_fb & S_MASK) != 8'h00) && ((p_fb & PID_MASK) == 8'h00);
    endfunction

    // Next header field to expect, from the flags parsed so far
    function automatic t_phase phase_after(input t_phase cur);
        logic [8:0] need;
        logic       x;
        t_phase     nxt;
        x = (p_fb & X_MASK) != 8'h00;
        need = '0;
        need[PH_EXT]  = x;
        need[PH_PID0] = x && ((p_ext & I_MASK) != 8'h00);
        need[PH_PID1] = need[PH_PID0] && p_long;
        need[PH_TL0]  = x && ((p_ext & L_MASK) != 8'h00);
        need[PH_TIDK] = x && ((p_ext & TK_MASK) != 8'h00);
        need[PH_TAG0] = carries_frame_tag();
        need[PH_TAG1] = need[PH_TAG0];
        need[PH_TAG2] = need[PH_TAG0];
        nxt = PH_DONE;
        for (int k = 8; k > 0; k--)
            if (need[k] && k > int'(cur))
                nxt = t_phase'(k);
        return nxt;
    endfunction

    // Assemble the result record from the fields parsed so far
    function automatic t_result packet_result(input logic cut_short);
        t_result r;
        logic    tag_done;
        r = '0;
        tag_done = 1'b0;
        r.descriptor_length = p_count[2:0];
        if (!cut_short && carries_frame_tag()) begin
            r.descriptor_length = 3'(p_count - TAG_BYTES);
            tag_done = 1'b1;
        end else if (cut_short && p_phase >= PH_TAG0 && p_phase <= PH_TAG2) begin
            r.descriptor_length = 3'(p_count - 4'(p_phase - PH_TAG0));
        end
        r.status          = cut_short;
        r.consumed_length = p_count;
        r.first_byte      = p_fb;
        r.extension_byte  = p_ext;
        r.picture_id      = p_pid;
        r.picture_id_long = p_long;
        r.tl0_pic_index   = p_tl0;
        r.tid_key_byte    = p_tidk;
        if (tag_done) begin
            r.frame_tag_bits = p_tag[4:0];
            r.part0_size     = p_tag[23:5];
            r.key_frame      = !p_tag[0];
        end
        return r;
    endfunction

    // Advance the model by one payload byte
    task automatic descriptor_step(input logic [7:0] d, input logic l,
                                   output logic got, output t_result r);
        got = 1'b0;
        r = '0;
        if (p_done) begin
            if (l)
                clear_parse();
            return;
        end
        case (p_phase)
            PH_FIRST: p_fb = d;
            PH_EXT:   p_ext = d;
            PH_PID0: begin
                p_long = d[7];
                p_pid  = {8'h00, d[6:0]};
            end
            PH_PID1:  p_pid = {p_pid[6:0], d};
            PH_TL0:   p_tl0 = d;
            PH_TIDK:  p_tidk = d;
            PH_TAG0:  p_tag = {16'h0000, d};
            PH_TAG1:  p_tag[15:8] = d;
            PH_TAG2:  p_tag[23:16] = d;
            default: ;
        endcase
        p_count = p_count + 4'd1;
        p_phase = phase_after(p_phase);
        if (p_phase == PH_DONE) begin
            r = packet_result(1'b0);
            got = 1'b1;
            p_done = 1'b1;
        end else if (l) begin
            r = packet_result(1'b1);
            got = 1'b1;
        end
        if (l)
            clear_parse();
    endtask

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ns: %s", $realtime, msg);
    endfunction

    function automatic void check_field(input string name, input logic [18:0] want,
                                        input logic [18:0] have);
        if (have !== want)
            note_failure($sformatf("%s mismatch: expected %0h, got %0h", name, want, have));
    endfunction

    // Predict on each input transfer, check each output transfer
    always @(posedge i_clk) begin : scoreboard
        logic    produced;
        t_result predicted;
        t_result seen;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            descriptor_step(i_data_byte, i_last_byte, produced, predicted);
            if (row_typed) begin
                produced = 1'b1;
                predicted = row_want;
            end
            if (produced)
                pending_results.push_back(predicted);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = '{o_status, o_descriptor_length, o_consumed_length, o_first_byte,
                     o_extension_byte, o_picture_id, o_picture_id_long, o_tl0_pic_index,
                     o_tid_key_byte, o_frame_tag_bits, o_part0_size, o_key_frame};
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result %h", seen));
            end else begin
                predicted = pending_results.pop_front();
                check_field("status", 19'(predicted.status), 19'(seen.status));
                check_field("descriptor_length", 19'(predicted.descriptor_length),
                            19'(seen.descriptor_length));
                check_field("consumed_length", 19'(predicted.consumed_length),
                            19'(seen.consumed_length));
                check_field("first_byte", 19'(predicted.first_byte), 19'(seen.first_byte));
                check_field("extension_byte", 19'(predicted.extension_byte),
                            19'(seen.extension_byte));
                check_field("picture_id", 19'(predicted.picture_id), 19'(seen.picture_id));
                check_field("picture_id_long", 19'(predicted.picture_id_long),
                            19'(seen.picture_id_long));
                check_field("tl0_pic_index", 19'(predicted.tl0_pic_index),
                            19'(seen.tl0_pic_index));
                check_field("tid_key_byte", 19'(predicted.tid_key_byte),
                            19'(seen.tid_key_byte));
                check_field("frame_tag_bits", 19'(predicted.frame_tag_bits),
                            19'(seen.frame_tag_bits));
                check_field("part0_size", predicted.part0_size, seen.part0_size);
                check_field("key_frame", 19'(predicted.key_frame), 19'(seen.key_frame));
            end
        end
    end

    // Receiver backpressure: switch at random between four ready patterns, one of them never stalling
    int unsigned stall_tick = 0;
    int unsigned stall_mode = 0;
    always @(negedge i_clk) begin
        stall_tick++;
        if (stall_tick % 256 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            2: i_out_ready <= ((stall_tick % 8) < 5);
            default: i_out_ready <= ((stall_tick % 16) >= 12);
        endcase
    end

    // Present one byte, hold it until the transfer, then maybe idle
    task automatic send_byte(input logic [7:0] d, input logic l, input logic typed,
                             input t_result want);
        int unsigned gap;
        gap = 0;
        @(negedge i_clk);
        i_data_byte <= d;
        i_last_byte <= l;
        i_in_valid  <= 1'b1;
        row_typed = typed;
        row_want  = want;
        do @(posedge i_clk); while (!o_in_ready);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = sender_idles ? $urandom_range(1, 6) : 0;
        end else begin
            burst_left--;
        end
        if (gap != 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drop valid, then hold off until every expected result has come
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Build one packet: a well-formed header with random content, sometimes cut short, or noise
    task automatic send_packet(input logic well_formed);
        logic [7:0]  pkt[$];
        logic [7:0]  fb;
        logic [7:0]  ext;
        logic [7:0]  pid_hi;
        int unsigned hdr_len;
        int unsigned cut;
        if (well_formed) begin
            fb = 8'($urandom);
            if ($urandom_range(0, 9) < 7)
                fb = fb | X_MASK;
            if ($urandom_range(0, 2) == 0)
                fb = (fb | S_MASK) & ~PID_MASK;
            pkt.push_back(fb);
            if ((fb & X_MASK) != 8'h00) begin
                ext = 8'($urandom);
                pkt.push_back(ext);
                if ((ext & I_MASK) != 8'h00) begin
                    pid_hi = 8'($urandom);
                    pkt.push_back(pid_hi);
                    if ((pid_hi & M_MASK) != 8'h00)
                        pkt.push_back(8'($urandom));
                end
                if ((ext & L_MASK) != 8'h00)
                    pkt.push_back(8'($urandom));
                if ((ext & TK_MASK) != 8'h00)
                    pkt.push_back(8'($urandom));
            end
            if (((fb & S_MASK) != 8'h00) && ((fb & PID_MASK) == 8'h00))
                repeat (3) pkt.push_back(8'($urandom));
            hdr_len = pkt.size();
            if ($urandom_range(0, 4) == 0) begin
                // cut the payload short somewhere inside or at the end of the header
                cut = $urandom_range(1, hdr_len);
                pkt = pkt[0:cut-1];
            end else begin
                repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
            end
        end else begin
            repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
        end
        sent_items += pkt.size();
        foreach (pkt[k])
            send_byte(pkt[k], k == pkt.size() - 1, 1'b0, '0);
    endtask

    function automatic t_stim_row plain(input logic [7:0] d, input logic l);
        return '{d, l, 1'b0, '0};
    endfunction

    initial begin : stimulus
        t_stim_row   rows[$];
        int unsigned pkt_no;
        pkt_no = 0;
        clear_parse();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Shortest header: one byte, no extension, no frame tag
        rows.push_back('{8'h00, 1'b1, 1'b1,
                        t_result'{1'b0, 3'd1, 4'd1, 8'h00, 8'h00, 15'h0000, 1'b0,
                                  8'h00, 8'h00, 5'h00, 19'h00000, 1'b0}});
        // Extension announced but payload ends: truncation
        rows.push_back('{8'hFF, 1'b1, 1'b1,
                        t_result'{1'b1, 3'd1, 4'd1, 8'hFF, 8'h00, 15'h0000, 1'b0,
                                  8'h00, 8'h00, 5'h00, 19'h00000, 1'b0}});
        // Longest header with a key frame tag, other fields mostly at their top, completes on the last byte
        rows.push_back(plain(8'h90, 1'b0));
        rows.push_back(plain(8'hFF, 1'b0));
        rows.push_back(plain(8'hFF, 1'b0));
        rows.push_back(plain(8'hFF, 1'b0));
        rows.push_back(plain(8'hFF, 1'b0));
        rows.push_back(plain(8'hFF, 1'b0));
        rows.push_back(plain(8'hFE, 1'b0));
        rows.push_back(plain(8'hFF, 1'b0));
        rows.push_back('{8'hFF, 1'b1, 1'b1,
                        t_result'{1'b0, 3'd6, 4'd9, 8'h90, 8'hFF, 15'h7FFF, 1'b1,
                                  8'hFF, 8'hFF, 5'h1E, 19'h7FFFF, 1'b1}});
        // Frame tag without extension, all zero, then an ignored byte
        rows.push_back(plain(8'h10, 1'b0));
        rows.push_back(plain(8'h00, 1'b0));
        rows.push_back(plain(8'h00, 1'b0));
        rows.push_back(plain(8'h00, 1'b0));
        rows.push_back(plain(8'h55, 1'b1));
        // Reserved R bit, TL0PICIDX and TID/KEYIDX, no picture id
        rows.push_back(plain(8'hC0, 1'b0));
        rows.push_back(plain(8'h70, 1'b0));
        rows.push_back(plain(8'h12, 1'b0));
        rows.push_back(plain(8'h34, 1'b1));
        // Payload ends inside the frame tag
        rows.push_back(plain(8'h10, 1'b0));
        rows.push_back(plain(8'h9D, 1'b0));
        rows.push_back(plain(8'h01, 1'b1));
        // Short picture id with K only, nonzero partition index so no frame tag
        rows.push_back(plain(8'h91, 1'b0));
        rows.push_back(plain(8'h90, 1'b0));
        rows.push_back(plain(8'h05, 1'b0));
        rows.push_back(plain(8'hE3, 1'b1));
        foreach (rows[k])
            send_byte(rows[k].data, rows[k].last, rows[k].typed, rows[k].want);
        sent_items += rows.size();

        // Hold off until the directed results are all in
        wait_drained();

        while (sent_items < 1900) begin
            pkt_no++;
            if (pkt_no % 40 == 0)
                sender_idles = ($urandom_range(0, 2) != 0);
            if (pkt_no % 150 == 0)
                wait_drained();
            send_packet($urandom_range(0, 9) != 0);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb_vp8_payload_descriptor_parser: PASS");
        else
            $display("tb_vp8_payload_descriptor_parser: FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("tb_vp8_payload_descriptor_parser: FAIL");
        $finish;
    end

endmodule
